// File: hdl/linear_probe_hash_set_macros.svh
// Assertion macros shared by the hash set RTL
`ifndef LINEAR_PROBE_HASH_SET_MACROS_SVH
`define LINEAR_PROBE_HASH_SET_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled in reset
`define LPHS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled in reset
`define LPHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LPHS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define LPHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: hdl/lphs_pkg.sv
// Types, constants and codes shared by the hash set modules
`timescale 1ns / 1ps
`default_nettype none

package lphs_pkg;

    localparam int KEY_FIELD_W    = 32;
    localparam int CNT_W          = 10;
    localparam int CNT_MAX        = 1023;
    localparam int DEF_TABLE_SIZE = 1024;
    localparam int DEF_KEY_WIDTH  = 32;
    localparam int FILL_NUM       = 17;
    localparam int FILL_DEN       = 20;

    typedef enum logic [1:0] {
        OP_MEMBER = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_CLEAR  = 2'd3
    } lphs_op_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_FULL     = 2'd1,
        ST_ZERO_KEY = 2'd2
    } lphs_status_t;

    typedef struct packed {
        lphs_op_t                op;
        logic [KEY_FIELD_W-1:0]  key;
    } lphs_req_t;

    typedef struct packed {
        logic                    found;
        lphs_status_t            status;
        logic [CNT_W-1:0]        entry_count;
    } lphs_rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic load_req;      // latch request, start probe at home slot
        logic rd_probe;      // read slot at probe index
        logic rd_scan;       // read slot at scan index
        logic probe_adv;     // step probe index
        logic probe_hit;     // key found at probe index
        logic probe_empty;   // empty slot at probe index
        logic wr_key_pos;    // store key at found empty slot
        logic wr_zero_pos;   // empty the deleted slot, start cluster scan
        logic wr_zero_scan;  // lift entry out of cluster for re-placing
        logic wr_mv_idx;     // re-place lifted entry
        logic scan_adv;      // step scan index
        logic wr_zero_clr;   // clearing sweep write
        logic count_zero;
        logic set_full;
        logic set_zero_key;
        logic rsp_load;
    } lphs_cmd_t;

    // Datapath to controller
    typedef struct packed {
        lphs_op_t op;
        logic     key_zero;
        logic     found;
        logic     pos_ok;
        logic     rd_zero;
        logic     hit_key;
        logic     hit_mv;
        logic     probe_last;
        logic     at_limit;
        logic     scan_end;
        logic     clr_last;
    } lphs_stat_t;

endpackage

`default_nettype wire

// File: hdl/lphs_datapath.sv
// Slot memory, probe and scan indices, entry count and result registers
`timescale 1ns / 1ps
`default_nettype none
`include "linear_probe_hash_set_macros.svh"

module lphs_datapath
    import lphs_pkg::*;
#(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE,
    parameter int KEY_WIDTH  = DEF_KEY_WIDTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lphs_cmd_t         cmd,
    input  wire lphs_req_t         req,
    input  wire logic [CNT_W-1:0]  fill_limit,
    output lphs_stat_t             stat,
    output lphs_rsp_t              result
);

    localparam int IDX_W = $clog2(TABLE_SIZE);

    logic [KEY_WIDTH-1:0]   slots_reg [TABLE_SIZE];
    logic [KEY_WIDTH-1:0]   rdata_reg;

    lphs_op_t               op_reg;
    logic [KEY_WIDTH-1:0]   key_reg, key_next;
    logic                   key_zero_reg;
    logic [KEY_WIDTH-1:0]   mv_reg;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [IDX_W-1:0]       n_reg, n_next;
    logic [IDX_W-1:0]       pos_reg;
    logic                   pos_ok_reg;
    logic                   found_reg;
    lphs_status_t           status_reg;
    logic [IDX_W-1:0]       scan_idx_reg;
    logic [IDX_W-1:0]       scan_n_reg;
    logic [IDX_W-1:0]       clr_idx_reg;
    logic [CNT_W-1:0]       count_reg, count_next;

    logic [KEY_WIDTH+KEY_FIELD_W-1:0] req_key_ext;
    logic [KEY_WIDTH+IDX_W-1:0]       key_home_ext;
    logic [KEY_WIDTH+IDX_W-1:0]       rd_home_ext;

    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [KEY_WIDTH-1:0]   wr_data;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic [4:0]             wr_vec;

    // Keys narrower than the field drop high bits; wider ones are zero-extended
    assign req_key_ext  = {{KEY_WIDTH{1'b0}}, req.key};
    assign key_next     = req_key_ext[KEY_WIDTH-1:0];
    assign key_home_ext = {{IDX_W{1'b0}}, key_next};
    assign rd_home_ext  = {{IDX_W{1'b0}}, rdata_reg};

    always_comb
    begin
        idx_next = idx_reg;
        n_next   = n_reg;
        if (cmd.load_req)
        begin
            idx_next = key_home_ext[IDX_W-1:0];
            n_next   = '0;
        end
        else if (cmd.wr_zero_scan)
        begin
            idx_next = rd_home_ext[IDX_W-1:0];
            n_next   = '0;
        end
        else if (cmd.probe_adv)
        begin
            idx_next = idx_reg + 1'b1;
            n_next   = n_reg + 1'b1;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.count_zero)
            count_next = '0;
        else if (cmd.wr_key_pos)
            count_next = count_reg + 1'b1;
        else if (cmd.wr_zero_pos && count_reg != '0)
            count_next = count_reg - 1'b1;
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pos_reg;
        wr_data = '0;
        if (cmd.wr_key_pos)
        begin
            wr_en   = 1'b1;
            wr_data = key_reg;
        end
        else if (cmd.wr_zero_pos)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.wr_zero_scan)
        begin
            wr_en   = 1'b1;
            wr_addr = scan_idx_reg;
        end
        else if (cmd.wr_mv_idx)
        begin
            wr_en   = 1'b1;
            wr_addr = idx_reg;
            wr_data = mv_reg;
        end
        else if (cmd.wr_zero_clr)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_idx_reg;
        end
    end

    assign rd_en   = cmd.rd_probe || cmd.rd_scan;
    assign rd_addr = cmd.rd_scan ? scan_idx_reg : idx_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slots_reg[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= slots_reg[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            clr_idx_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            // wraps back to zero at the end of each sweep
            if (cmd.wr_zero_clr)
                clr_idx_reg <= clr_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        n_reg   <= n_next;
        if (cmd.load_req)
        begin
            op_reg       <= req.op;
            key_reg      <= key_next;
            key_zero_reg <= (key_next == '0);
            found_reg    <= 1'b0;
            pos_ok_reg   <= 1'b0;
            status_reg   <= ST_DONE;
        end
        if (cmd.probe_hit)
        begin
            pos_reg   <= idx_reg;
            found_reg <= 1'b1;
        end
        if (cmd.probe_empty)
        begin
            pos_reg    <= idx_reg;
            pos_ok_reg <= 1'b1;
        end
        if (cmd.set_full)
            status_reg <= ST_FULL;
        if (cmd.set_zero_key)
            status_reg <= ST_ZERO_KEY;
        if (cmd.wr_zero_pos)
        begin
            scan_idx_reg <= pos_reg + 1'b1;
            scan_n_reg   <= IDX_W'(1);
        end
        else if (cmd.scan_adv)
        begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
            scan_n_reg   <= scan_n_reg + 1'b1;
        end
        if (cmd.wr_zero_scan)
            mv_reg <= rdata_reg;
    end

    always_comb
    begin
        stat.op         = op_reg;
        stat.key_zero   = key_zero_reg;
        stat.found      = found_reg;
        stat.pos_ok     = pos_ok_reg;
        stat.rd_zero    = (rdata_reg == '0);
        stat.hit_key    = (rdata_reg == key_reg);
        stat.hit_mv     = (rdata_reg == mv_reg);
        stat.probe_last = &n_reg;
        stat.at_limit   = (count_reg >= fill_limit);
        // scan count wraps to zero once every other slot has been visited
        stat.scan_end   = (scan_n_reg == '0);
        stat.clr_last   = &clr_idx_reg;
    end

    assign result.found       = found_reg;
    assign result.status      = status_reg;
    assign result.entry_count = count_reg;

    assign wr_vec = {cmd.wr_key_pos, cmd.wr_zero_pos, cmd.wr_zero_scan,
                     cmd.wr_mv_idx, cmd.wr_zero_clr};

    `LPHS_ASSERT_NOW(a_single_write, clk, rst_n, 1'b1, $onehot0(wr_vec), "two slot writes in one cycle")
    `LPHS_ASSERT_NOW(a_no_zero_store, clk, rst_n, cmd.wr_key_pos, key_reg != '0, "zero key stored")

endmodule

`default_nettype wire

// File: hdl/lphs_ctrl.sv
// Request sequencer: probe, insert, delete with cluster re-placing, clearing sweep
`timescale 1ns / 1ps
`default_nettype none
`include "linear_probe_hash_set_macros.svh"

module lphs_ctrl
    import lphs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    input  wire lphs_stat_t  stat,
    input  wire logic        rsp_free,
    output logic             req_ready,
    output lphs_cmd_t        cmd
);

    typedef enum logic [3:0] {
        S_INIT_CLR,
        S_IDLE,
        S_PRB_RD,
        S_PRB_CMP,
        S_ACT,
        S_SCN_RD,
        S_SCN_CMP,
        S_RP_RD,
        S_RP_CMP,
        S_OP_CLR,
        S_RESP
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_INIT_CLR:
            begin
                cmd.wr_zero_clr = 1'b1;
                if (stat.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_PRB_RD;
                end
            end
            S_PRB_RD:
            begin
                // zero key never probes
                if (stat.key_zero)
                    state_next = S_ACT;
                else
                begin
                    cmd.rd_probe = 1'b1;
                    state_next   = S_PRB_CMP;
                end
            end
            S_PRB_CMP:
            begin
                if (stat.rd_zero)
                begin
                    cmd.probe_empty = 1'b1;
                    state_next      = S_ACT;
                end
                else if (stat.hit_key)
                begin
                    cmd.probe_hit = 1'b1;
                    state_next    = S_ACT;
                end
                else if (stat.probe_last)
                    state_next = S_ACT;
                else
                begin
                    cmd.probe_adv = 1'b1;
                    state_next    = S_PRB_RD;
                end
            end
            S_ACT:
            begin
                state_next = S_RESP;
                case (stat.op)
                    OP_INSERT:
                    begin
                        if (stat.key_zero)
                            cmd.set_zero_key = 1'b1;
                        else if (!stat.found)
                        begin
                            if (stat.at_limit || !stat.pos_ok)
                                cmd.set_full = 1'b1;
                            else
                                cmd.wr_key_pos = 1'b1;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (stat.found)
                        begin
                            cmd.wr_zero_pos = 1'b1;
                            state_next      = S_SCN_RD;
                        end
                    end
                    OP_CLEAR:
                        state_next = S_OP_CLR;
                    default:
                        state_next = S_RESP;
                endcase
            end
            S_SCN_RD:
            begin
                if (stat.scan_end)
                    state_next = S_RESP;
                else
                begin
                    cmd.rd_scan = 1'b1;
                    state_next  = S_SCN_CMP;
                end
            end
            S_SCN_CMP:
            begin
                // an empty slot closes the cluster
                if (stat.rd_zero)
                    state_next = S_RESP;
                else
                begin
                    cmd.wr_zero_scan = 1'b1;
                    state_next       = S_RP_RD;
                end
            end
            S_RP_RD:
            begin
                cmd.rd_probe = 1'b1;
                state_next   = S_RP_CMP;
            end
            S_RP_CMP:
            begin
                if (stat.rd_zero)
                begin
                    cmd.wr_mv_idx = 1'b1;
                    cmd.scan_adv  = 1'b1;
                    state_next    = S_SCN_RD;
                end
                else if (stat.hit_mv || stat.probe_last)
                begin
                    cmd.scan_adv = 1'b1;
                    state_next   = S_SCN_RD;
                end
                else
                begin
                    cmd.probe_adv = 1'b1;
                    state_next    = S_RP_RD;
                end
            end
            S_OP_CLR:
            begin
                cmd.wr_zero_clr = 1'b1;
                if (stat.clr_last)
                begin
                    cmd.count_zero = 1'b1;
                    state_next     = S_RESP;
                end
            end
            S_RESP:
            begin
                // hold until the result register is free
                if (rsp_free)
                begin
                    cmd.rsp_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_INIT_CLR;
        else
            state_reg <= state_next;
    end

    `LPHS_ASSERT_NOW(a_full_reason, clk, rst_n, cmd.set_full, stat.at_limit || !stat.pos_ok, "full refusal without cause")
    `LPHS_ASSERT_NOW(a_load_free, clk, rst_n, cmd.rsp_load, rsp_free, "result loaded over a pending one")

endmodule

`default_nettype wire

// File: hdl/linear_probe_hash_set.sv
// Top level: linear probing hash set with fill limit register and result register
//
// Open-addressed set of keys held in a TABLE_SIZE-entry slot memory (key zero
// means empty; TABLE_SIZE must be a power of two). Each request does member,
// insert, delete or clear and returns found, status and entry count. The slot
// memory has one read and one write port with registered read data, so each
// probed slot is read in S_PRB_RD and compared in S_PRB_CMP. Member and insert
// probe from the home slot until a hit, an empty slot or the whole table (a zero
// key does not probe); delete then re-places every entry of the following
// cluster up to the empty slot that closes it; clear sweeps every slot. After
// reset the block runs a clearing sweep before it takes the first request. A new
// request is taken while the previous result still waits in the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "linear_probe_hash_set_macros.svh"

module linear_probe_hash_set
    import lphs_pkg::*;
#(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE,
    parameter int KEY_WIDTH  = DEF_KEY_WIDTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire lphs_req_t         req,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output lphs_rsp_t              rsp,
    input  wire logic              cfg_write_en,
    input  wire logic [CNT_W-1:0]  cfg_write_data
);

    localparam longint FILL_RAW = (longint'(TABLE_SIZE) * FILL_NUM) / FILL_DEN;
    localparam logic [CNT_W-1:0] FILL_RESET =
        CNT_W'((FILL_RAW > longint'(CNT_MAX)) ? longint'(CNT_MAX) : FILL_RAW);

    logic [CNT_W-1:0] fill_limit_reg;
    logic             rsp_valid_reg, rsp_valid_next;
    lphs_rsp_t        rsp_reg;
    logic             rsp_free;
    lphs_cmd_t        cmd;
    lphs_stat_t       stat;
    lphs_rsp_t        result;

    assign rsp_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.rsp_load)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_limit_reg <= FILL_RESET;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
                fill_limit_reg <= cfg_write_data;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rsp_load)
            rsp_reg <= result;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    lphs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .stat      (stat),
        .rsp_free  (rsp_free),
        .req_ready (req_ready),
        .cmd       (cmd)
    );

    lphs_datapath #(
        .TABLE_SIZE (TABLE_SIZE),
        .KEY_WIDTH  (KEY_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .req        (req),
        .fill_limit (fill_limit_reg),
        .stat       (stat),
        .result     (result)
    );

    `LPHS_ASSERT_NEXT(a_load_valid, clk, rst_n, cmd.rsp_load, rsp_valid_reg, "loaded result not presented")

endmodule

`default_nettype wire

// File: dv/linear_probe_hash_set_test.sv
// Testbench for the linear probing hash set: predicted responses, random traffic and stalls
`timescale 1ns / 1ps

module linear_probe_hash_set_test;
    import lphs_pkg::*;

    localparam int TBL = DEF_TABLE_SIZE;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             req_valid = 1'b0;
    logic             req_ready;
    lphs_req_t        req = '0;
    logic             rsp_valid;
    logic             rsp_ready = 1'b0;
    lphs_rsp_t        rsp;
    logic             cfg_write_en = 1'b0;
    logic [CNT_W-1:0] cfg_write_data = '0;

    // Shadow copy of the set
    logic [KEY_FIELD_W-1:0] shadow_slots [TBL];
    int unsigned            shadow_count;
    logic [CNT_W-1:0]       shadow_limit;

    lphs_req_t req_backlog [$];
    lphs_rsp_t rsp_due [$];

    int err_count = 0;
    int send_idle_pct = 0;
    int stall_idle_pct = 0;
    int send_gap = 0;
    int stall_gap = 0;

    linear_probe_hash_set dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req            (req),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .rsp            (rsp),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        $display("%0t ns mismatch: %s", $time, what);
        err_count++;
    endtask

    // Walk the probe path; pos is the hit, the first empty slot, or TBL if none
    function automatic bit seek_key(input logic [KEY_FIELD_W-1:0] k, output int pos);
        int idx;
        idx = int'(k & 32'(TBL - 1));
        pos = TBL;
        for (int n = 0; n < TBL; n++)
        begin
            if (shadow_slots[idx] == '0)
            begin
                pos = idx;
                return 1'b0;
            end
            if (shadow_slots[idx] == k)
            begin
                pos = idx;
                return 1'b1;
            end
            idx = (idx + 1) % TBL;
        end
        return 1'b0;
    endfunction

    function automatic lphs_rsp_t apply_request(input lphs_req_t r);
        lphs_rsp_t        res;
        int               pos;
        int               idx;
        int               spot;
        bit               hit;
        logic [KEY_FIELD_W-1:0] moved;
        hit = 1'b0;
        pos = 0;
        res.status = ST_DONE;
        if (r.key != '0)
            hit = seek_key(r.key, pos);
        case (r.op)
            OP_INSERT:
            begin
                if (r.key == '0)
                    res.status = ST_ZERO_KEY;
                else if (!hit)
                begin
                    if (shadow_count >= shadow_limit || pos >= TBL)
                        res.status = ST_FULL;
                    else
                    begin
                        shadow_slots[pos] = r.key;
                        shadow_count++;
                    end
                end
            end
            OP_DELETE:
            begin
                if (hit)
                begin
                    shadow_slots[pos] = '0;
                    if (shadow_count > 0)
                        shadow_count--;
                    idx = pos;
                    // lift each following cluster entry and place it again
                    for (int n = 1; n < TBL; n++)
                    begin
                        idx = (idx + 1) % TBL;
                        moved = shadow_slots[idx];
                        if (moved == '0)
                            break;
                        shadow_slots[idx] = '0;
                        if (!seek_key(moved, spot) && spot < TBL)
                            shadow_slots[spot] = moved;
                    end
                end
            end
            OP_CLEAR:
            begin
                foreach (shadow_slots[i])
                    shadow_slots[i] = '0;
                shadow_count = 0;
            end
            default: ;
        endcase
        res.found = hit;
        res.entry_count = shadow_count[CNT_W-1:0];
        return res;
    endfunction

    // Request side: hold each item until its transfer, idle in bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            send_gap  <= 0;
        end
        else
        begin
            if (req_valid && req_ready)
                rsp_due.push_back(apply_request(req));
            if (!req_valid || req_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap  <= send_gap - 1;
                    req_valid <= 1'b0;
                end
                else if (req_backlog.size() > 0 && $urandom_range(99) < send_idle_pct)
                begin
                    send_gap  <= $urandom_range(0, 15);
                    req_valid <= 1'b0;
                end
                else if (req_backlog.size() > 0)
                begin
                    req_valid <= 1'b1;
                    req       <= req_backlog.pop_front();
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Response side: check each transfer against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            stall_gap <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (rsp_due.size() == 0)
                    flag_mismatch("response with none outstanding");
                else
                begin
                    lphs_rsp_t want;
                    want = rsp_due.pop_front();
                    if (rsp.found !== want.found)
                        flag_mismatch($sformatf("found %0b, want %0b", rsp.found, want.found));
                    if (rsp.status !== want.status)
                        flag_mismatch($sformatf("status %0d, want %0d",
                                                rsp.status, want.status));
                    if (rsp.entry_count !== want.entry_count)
                        flag_mismatch($sformatf("entry_count %0d, want %0d",
                                                rsp.entry_count, want.entry_count));
                end
            end
            if (stall_gap > 0)
            begin
                stall_gap <= stall_gap - 1;
                rsp_ready <= 1'b0;
            end
            else if ($urandom_range(99) < stall_idle_pct)
            begin
                stall_gap <= $urandom_range(0, 15);
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    task automatic push_req(input lphs_op_t op, input logic [KEY_FIELD_W-1:0] k);
        lphs_req_t r;
        r.op  = op;
        r.key = k;
        req_backlog.push_back(r);
    endtask

    // Drain everything, let the block settle, return on a falling edge
    task automatic wait_idle();
        @(negedge clk);
        while (req_backlog.size() != 0 || req_valid || rsp_due.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic set_fill_limit(input logic [CNT_W-1:0] v);
        @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        shadow_limit = v;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic random_phase(input int lim, input int n_items, input int pool_n,
                                input int spread, input int send_pct, input int stall_pct);
        logic [KEY_FIELD_W-1:0] pool [$];
        logic [KEY_FIELD_W-1:0] k;
        int base;
        int pick;
        set_fill_limit(CNT_W'(lim));
        send_idle_pct  = send_pct;
        stall_idle_pct = stall_pct;
        // crowd the keys' home slots into a narrow window to force long clusters
        base = $urandom_range(0, TBL - 1);
        for (int i = 0; i < pool_n; i++)
        begin
            k = $urandom;
            k[9:0] = 10'((base + $urandom_range(0, spread - 1)) % TBL);
            if (k == '0)
                k = 32'h0000_0400;
            pool.push_back(k);
        end
        for (int i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(99);
            k = pool[$urandom_range(0, pool_n - 1)];
            if (pick < 2)
                push_req(OP_CLEAR, k);
            else if (pick < 5)
                push_req(lphs_op_t'($urandom_range(0, 3)), '0);
            else if (pick < 10)
                push_req(lphs_op_t'($urandom_range(0, 2)), $urandom);
            else if (pick < 50)
                push_req(OP_INSERT, k);
            else if (pick < 75)
                push_req(OP_MEMBER, k);
            else
                push_req(OP_DELETE, k);
        end
        wait_idle();
    endtask

    initial
    begin
        foreach (shadow_slots[i])
            shadow_slots[i] = '0;
        shadow_count = 0;
        shadow_limit = CNT_W'(870);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // zero key, wrap at the table end, duplicate insert, cluster repair on delete
        send_idle_pct  = 20;
        stall_idle_pct = 5;
        push_req(OP_MEMBER, '0);
        push_req(OP_INSERT, '0);
        push_req(OP_DELETE, '0);
        push_req(OP_INSERT, 32'h0000_03FF);
        push_req(OP_INSERT, 32'h0000_07FF);
        push_req(OP_INSERT, 32'h0000_0BFF);
        push_req(OP_INSERT, 32'h0000_0400);
        push_req(OP_INSERT, 32'hFFFF_FFFF);
        push_req(OP_INSERT, 32'h0000_03FF);
        push_req(OP_MEMBER, 32'h0000_13FF);
        push_req(OP_DELETE, 32'h0000_03FF);
        push_req(OP_MEMBER, 32'hFFFF_FFFF);
        push_req(OP_DELETE, 32'h0000_13FF);
        push_req(OP_CLEAR, 32'h0000_07FF);
        push_req(OP_MEMBER, 32'h0000_07FF);
        push_req(OP_INSERT, 32'h8000_0000);
        wait_idle();

        // limit of one: present key still answers at the limit
        set_fill_limit(CNT_W'(1));
        push_req(OP_INSERT, 32'h0000_0001);
        push_req(OP_INSERT, 32'h0000_0002);
        push_req(OP_INSERT, 32'h0000_0001);
        push_req(OP_DELETE, 32'h0000_0001);
        push_req(OP_INSERT, 32'h0000_0002);
        wait_idle();

        // limit of zero refuses every new key
        set_fill_limit('0);
        push_req(OP_INSERT, 32'h0000_0005);
        push_req(OP_CLEAR, 32'h0000_0002);
        push_req(OP_INSERT, 32'h0000_0005);
        wait_idle();

        random_phase(870, 250, 16, 24, 20, 5);
        random_phase(12, 200, 40, 30, 0, 0);
        random_phase(CNT_MAX, 250, 64, 20, 40, 10);
        random_phase(3, 150, 8, 10, 30, 5);
        random_phase($urandom_range(1, CNT_MAX), 200, 24, 24, 25, 8);
        random_phase(1, 100, 4, 8, 10, 3);
        // last stretch runs flat out
        random_phase($urandom_range(4, 40), 200, 20, 24, 0, 0);

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #100000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
